[sv/spg_pkg.sv]
// Shared types and constants for the scanline polygon span generator.
// No dependencies.
package spg_pkg;

	localparam int MaxVertsDef     = 64;
	localparam int MaxCrossingsDef = 64;
	localparam int ResultLimit     = 32;

	localparam logic [1:0] RegClipEnable = 2'd0;
	localparam logic [1:0] RegClipXMin   = 2'd1;
	localparam logic [1:0] RegClipXMax   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RD0,
		ST_EDGE,
		ST_DIV,
		ST_WRX,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_WR,
		ST_PAIR_RD,
		ST_PAIR_A,
		ST_PAIR_B,
		ST_EMPTY
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // write vertex
		logic scan_init;  // latch scan row, clear counters
		logic edge_rd;    // read vertex i / next
		logic edge_eval;  // compute edge test, start divide
		logic div_step;   // one quotient bit
		logic wr_cross;   // store crossing
		logic sort_rd;    // read pair j, j+1
		logic sort_wr;    // write swapped pair
		logic pair_rd;    // read pair
		logic pair_a;
		logic pair_b;     // emit pair, advance index
		logic emit_empty;
		logic [1:0] sel;  // misc step select
	} spg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic edge_last;   // current edge is the last one
		logic no_verts;
		logic crosses;     // edge crosses the scanline
		logic cross_full;
		logic div_done;
		logic need_swap;
		logic sort_inner_end;
		logic sort_done;
		logic pair_end;
		logic any_emitted;
	} spg_stat_t;

endpackage

[sv/spg_ctrl.sv]
// Controller state machine for the span generator.
// Depends on spg_pkg.
module spg_ctrl import spg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      cmd,
	input  spg_stat_t st,
	output spg_cmd_t  cm,
	output logic      busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cm = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (!cmd) begin
						cm.load = 1'b1;
					end else begin
						cm.scan_init = 1'b1;
						state_d = ST_RD0;
					end
				end
			end
			ST_LOAD: state_d = ST_IDLE;
			ST_RD0: begin
				if (st.no_verts) state_d = ST_SORT_RD;
				else begin
					cm.edge_rd = 1'b1;
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				cm.edge_eval = 1'b1;
				if (st.crosses && st.cross_full) state_d = ST_SORT_RD;
				else if (st.crosses) state_d = ST_DIV;
				else if (st.edge_last) state_d = ST_SORT_RD;
				else state_d = ST_RD0;
			end
			ST_DIV: begin
				cm.div_step = 1'b1;
				if (st.div_done) state_d = ST_WRX;
			end
			ST_WRX: begin
				cm.wr_cross = 1'b1;
				state_d = st.edge_last ? ST_SORT_RD : ST_RD0;
			end
			ST_SORT_RD: begin
				if (st.sort_done) state_d = ST_PAIR_RD;
				else begin
					cm.sort_rd = 1'b1;
					state_d = ST_SORT_CMP;
				end
			end
			ST_SORT_CMP: begin
				if (st.need_swap) state_d = ST_SORT_WR;
				else begin
					cm.sel = 2'd1;
					state_d = ST_SORT_RD;
				end
			end
			ST_SORT_WR: begin
				cm.sort_wr = 1'b1;
				state_d = ST_SORT_RD;
			end
			ST_PAIR_RD: begin
				if (st.pair_end) state_d = st.any_emitted ? ST_IDLE : ST_EMPTY;
				else begin
					cm.pair_rd = 1'b1;
					state_d = ST_PAIR_A;
				end
			end
			ST_PAIR_A: begin
				cm.pair_a = 1'b1;
				state_d = ST_PAIR_B;
			end
			ST_PAIR_B: begin
				cm.pair_b = 1'b1;
				state_d = ST_PAIR_RD;
			end
			ST_EMPTY: begin
				cm.emit_empty = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[sv/spg_dp.sv]
// Datapath: vertex and crossing memories, edge test, serial divider, sort, clip.
// Depends on spg_pkg.
module spg_dp import spg_pkg::*; #(
	parameter int MAX_VERTS     = MaxVertsDef,
	parameter int MAX_CROSSINGS = MaxCrossingsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spg_cmd_t           cm,
	input  logic               first_vertex,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic signed [15:0] scan_y,
	input  logic               clip_enable,
	input  logic signed [15:0] clip_x_min,
	input  logic signed [15:0] clip_x_max,
	output spg_stat_t          st,
	output logic               span_strobe,
	output logic               span_valid,
	output logic signed [15:0] span_left,
	output logic signed [15:0] span_right,
	output logic signed [15:0] span_row,
	output logic               last
);

	localparam int VW = $clog2(MAX_VERTS + 1);
	localparam int VA = $clog2(MAX_VERTS);
	localparam int CW = $clog2(MAX_CROSSINGS + 1);
	localparam int CA = $clog2(MAX_CROSSINGS);
	localparam int RW = $clog2(ResultLimit + 1);

	logic [31:0] vmem [MAX_VERTS];
	logic [15:0] cmem [MAX_CROSSINGS];

	logic [VW-1:0] vcount_q;
	logic [VW-1:0] ei_q;       // edge index
	logic [CW-1:0] n_q;        // crossing count
	logic [CW-1:0] sj_q, si_q; // sort indexes
	logic [CW-1:0] pi_q;       // crossing read index for pairing
	logic [RW-1:0] k_q;
	logic signed [15:0] row_q;

	// vertex reads
	logic [31:0] va_q, vb_q;
	logic [VW-1:0] nx;
	assign nx = (ei_q + VW'(1) < vcount_q) ? ei_q + VW'(1) : '0;

	always_ff @(posedge clk) begin
		if (cm.load && vcount_q < VW'(MAX_VERTS) || cm.load && first_vertex)
			vmem[first_vertex ? VA'(0) : vcount_q[VA-1:0]] <= {vertex_y, vertex_x};
		if (cm.edge_rd) begin
			va_q <= vmem[ei_q[VA-1:0]];
			vb_q <= vmem[nx[VA-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= '0;
		else if (cm.load) begin
			if (first_vertex) vcount_q <= VW'(1);
			else if (vcount_q < VW'(MAX_VERTS)) vcount_q <= vcount_q + VW'(1);
		end
	end

	// edge evaluation
	logic signed [16:0] y1, y2, x1, x2, dy, d1, d2, dx;
	assign x1 = 17'(signed'(va_q[15:0]));
	assign y1 = 17'(signed'(va_q[31:16]));
	assign x2 = 17'(signed'(vb_q[15:0]));
	assign y2 = 17'(signed'(vb_q[31:16]));
	assign dy = y2 - y1;
	assign d1 = 17'(row_q) - y1;
	assign d2 = 17'(row_q) - y2;
	assign dx = x2 - x1;
	logic crosses;
	assign crosses = (dy != '0) && (d1[16] != d2[16]);

	// product |d*2dx| fits 35 bits; quotient fits in 18 bits magnitude
	logic [34:0] num_q;
	logic [16:0] den_q;
	logic [17:0] quo_q;
	logic [17:0] rem_q;
	logic neg_q;
	logic signed [16:0] base_q;
	logic [5:0] dcnt_q;
	logic signed [16:0] dsel;
	logic signed [17:0] dx2;
	logic signed [34:0] prod;
	assign dx2 = {dx, 1'b0};
	assign dsel = dx2[17] ? d2 : d1;
	assign prod = 35'(dsel) * 35'(dx2);

	always_ff @(posedge clk) begin
		if (cm.edge_eval) begin
			num_q  <= prod[34] ? 35'(-prod) : 35'(prod);
			den_q  <= dy[16] ? 17'(-dy) : 17'(dy);
			neg_q  <= prod[34] ^ dy[16];
			base_q <= dx2[17] ? x2 : x1;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (cm.div_step) begin
			logic [18:0] tr;
			tr = {rem_q, num_q[34]};
			num_q <= {num_q[33:0], 1'b0};
			if (tr >= 19'(den_q)) begin
				rem_q <= 18'(tr - 19'(den_q));
				quo_q <= {quo_q[16:0], 1'b1};
			end else begin
				rem_q <= tr[17:0];
				quo_q <= {quo_q[16:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cm.edge_eval) dcnt_q <= '0;
		else if (cm.div_step) dcnt_q <= dcnt_q + 6'd1;
	end

	// quotient bits beyond 18 are zero since |q| <= 2|dx|
	logic signed [19:0] qs, t, crossing;
	assign qs = neg_q ? -20'(quo_q) : 20'(quo_q);
	assign t = qs + 20'sd1;
	assign crossing = (t >>> 1) + 20'(base_q);

	// sort
	logic [15:0] sa_q, sb_q;
	logic [CW-1:0] j1;
	assign j1 = sj_q + CW'(1);
	assign st.need_swap = $signed(sa_q) > $signed(sb_q);

	always_ff @(posedge clk) begin
		if (cm.wr_cross) cmem[n_q[CA-1:0]] <= crossing[15:0];
		else if (cm.sort_wr) begin
			cmem[sj_q[CA-1:0]] <= sb_q;
			cmem[j1[CA-1:0]]   <= sa_q;
		end
		if (cm.sort_rd) begin
			sa_q <= cmem[sj_q[CA-1:0]];
			sb_q <= cmem[j1[CA-1:0]];
		end else if (cm.pair_rd) begin
			sa_q <= cmem[pi_q[CA-1:0]];
			sb_q <= cmem[CA'(pi_q + CW'(1))];
		end
	end

	// pairing and clipping
	logic signed [15:0] cl, cr;
	logic emit_ok;

	// bubble pass bookkeeping
	logic sort_adv;
	assign sort_adv = cm.sort_wr || (cm.sel == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ei_q <= '0; n_q <= '0; sj_q <= '0; si_q <= '0; pi_q <= '0; k_q <= '0;
		end else if (cm.scan_init) begin
			ei_q <= '0; n_q <= '0; sj_q <= '0; pi_q <= '0; k_q <= '0;
		end else begin
			if (cm.edge_eval && !crosses) ei_q <= ei_q + VW'(1);
			if (cm.wr_cross) begin
				ei_q <= ei_q + VW'(1);
				n_q  <= n_q + CW'(1);
			end
			if (cm.edge_eval && (!crosses && st.edge_last || crosses && st.cross_full)
			    || cm.wr_cross && st.edge_last || st.no_verts && cm.sel == 2'd0 && 1'b0)
				si_q <= cm.wr_cross ? n_q + CW'(1) : n_q;
			if (sort_adv) begin
				if (j1 + CW'(1) >= si_q) begin
					sj_q <= '0;
					si_q <= si_q - CW'(1);
				end else sj_q <= j1;
			end
			if (cm.pair_b) begin
				pi_q <= pi_q + CW'(2);
				if (emit_ok) k_q <= k_q + RW'(1);
			end
		end
	end

	// edge loop status
	assign st.no_verts   = (vcount_q == '0);
	assign st.edge_last  = (ei_q + VW'(1) >= vcount_q);
	assign st.crosses    = crosses;
	assign st.cross_full = (n_q >= CW'(MAX_CROSSINGS));
	assign st.div_done   = (dcnt_q == 6'd34);
	assign st.sort_inner_end = (j1 + CW'(1) >= si_q);
	assign st.sort_done  = (si_q <= CW'(1));

	always_comb begin
		cl = $signed(sa_q);
		cr = $signed(sb_q);
		emit_ok = 1'b1;
		if (clip_enable) begin
			if (cl < clip_x_min) begin
				if (cr < clip_x_min) emit_ok = 1'b0;
				cl = clip_x_min;
			end
			if (cr > clip_x_max) begin
				if (cl > clip_x_max) emit_ok = 1'b0;
				cr = clip_x_max;
			end
		end
	end

	logic [CW-1:0] pi2;
	assign pi2 = pi_q + CW'(2);
	assign st.pair_end = (pi2 > n_q) || (k_q >= RW'(ResultLimit));
	assign st.any_emitted = (k_q != '0);

	// hold one span until the next is known so last can be set
	logic hold_q;
	logic signed [15:0] hl_q, hr_q;
	logic out_fire, out_empty, out_last;
	logic pend_end_q;

	always_ff @(posedge clk) begin
		if (cm.scan_init) row_q <= scan_y;
		if (cm.pair_b && emit_ok) begin
			hl_q <= cl;
			hr_q <= cr;
		end
		if (out_fire) begin
			span_left  <= out_empty ? '0 : hl_q;
			span_right <= out_empty ? '0 : hr_q;
			span_row   <= row_q;
		end
	end

	// a held span goes out when a newer one replaces it or when pairing ends
	logic pair_stop;
	assign pair_stop = (!cm.pair_rd && !cm.pair_a && !cm.pair_b) && hold_q && pend_end_q;
	assign out_empty = cm.emit_empty;
	assign out_last  = cm.emit_empty || pair_stop;
	assign out_fire  = cm.emit_empty || (cm.pair_b && emit_ok && hold_q) || pair_stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0; pend_end_q <= 1'b0;
			span_strobe <= 1'b0; span_valid <= 1'b0; last <= 1'b0;
		end else begin
			span_strobe <= out_fire;
			span_valid  <= !out_empty;
			last        <= out_last;
			pend_end_q  <= cm.pair_b || cm.pair_a || cm.pair_rd || cm.sort_rd || 1'b1;
			if (cm.scan_init || pair_stop) hold_q <= 1'b0;
			else if (cm.pair_b && emit_ok) hold_q <= 1'b1;
		end
	end

endmodule

[sv/scanline_polygon_span_gen_top.sv]
// Top level of the scanline polygon span generator: config registers,
// controller and datapath. Depends on spg_pkg, spg_ctrl, spg_dp.
//
// channel | signals                                         | handshake
// cmd in  | cmd first_vertex vertex_x vertex_y scan_y       | start & !busy
// span out| span_valid span_left span_right span_row last   | span_strobe, one cycle
// cfg     | cfg_we cfg_index cfg_data                       | cfg_we
//
// A load is written without leaving the idle state. A scan reads and tests each
// edge, runs a serial 35-step divider for each crossing, then bubble-sorts the
// crossing memory and pairs the sorted crossings. Reset clears control only;
// the memories need no clearing. Spans come one per strobe and cannot be held off.
module scanline_polygon_span_gen_top import spg_pkg::*; #(
	parameter int MAX_VERTS     = MaxVertsDef,
	parameter int MAX_CROSSINGS = MaxCrossingsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic               first_vertex,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic signed [15:0] scan_y,
	output logic               span_strobe,
	output logic               span_valid,
	output logic signed [15:0] span_left,
	output logic signed [15:0] span_right,
	output logic signed [15:0] span_row,
	output logic               last,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic clip_enable_q;
	logic signed [15:0] clip_x_min_q, clip_x_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_enable_q <= 1'b0;
			clip_x_min_q  <= 16'sd0;
			clip_x_max_q  <= 16'sd639;
		end else if (cfg_we) begin
			if (cfg_index == RegClipEnable) clip_enable_q <= cfg_data[0];
			if (cfg_index == RegClipXMin)   clip_x_min_q  <= cfg_data;
			if (cfg_index == RegClipXMax)   clip_x_max_q  <= cfg_data;
		end
	end

	spg_cmd_t  cm;
	spg_stat_t st;

	spg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.st(st), .cm(cm), .busy(busy)
	);

	spg_dp #(.MAX_VERTS(MAX_VERTS), .MAX_CROSSINGS(MAX_CROSSINGS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cm(cm),
		.first_vertex(first_vertex), .vertex_x(vertex_x), .vertex_y(vertex_y),
		.scan_y(scan_y), .clip_enable(clip_enable_q),
		.clip_x_min(clip_x_min_q), .clip_x_max(clip_x_max_q),
		.st(st), .span_strobe(span_strobe), .span_valid(span_valid),
		.span_left(span_left), .span_right(span_right), .span_row(span_row),
		.last(last)
	);

`ifndef SYNTHESIS
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		span_strobe && !span_valid |-> last) else $error("empty item without last");
	a_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		span_strobe |-> busy || last) else $error("item outside a scan");
`endif

endmodule

[dv/scanline_polygon_span_gen_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for scanline_polygon_span_gen_top: loads polygons, scans lines and checks
// every span strobe against a local span predictor. Depends on spg_pkg and the RTL.
module scanline_polygon_span_gen_top_tb;
	import spg_pkg::*;

	localparam int NVERT = MaxVertsDef;
	localparam int NCROSS = MaxCrossingsDef;
	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		logic              cmd;
		logic              fv;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] sy;
	} poly_cmd_t;

	typedef struct {
		logic              valid;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic signed [15:0] row;
		logic              last;
	} span_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cmd = 1'b0;
	logic first_vertex = 1'b0;
	logic signed [15:0] vertex_x = '0;
	logic signed [15:0] vertex_y = '0;
	logic signed [15:0] scan_y = '0;
	logic span_strobe, span_valid, last;
	logic signed [15:0] span_left, span_right, span_row;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = RegClipEnable;
	logic [15:0] cfg_data = '0;

	scanline_polygon_span_gen_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	poly_cmd_t cmd_q[$];
	span_t span_q[$];
	poly_cmd_t cur;
	int gap = 0;
	bit no_idle = 0;
	int errors = 0;
	int cycles = 0;

	// predictor state
	logic signed [15:0] vx_mem[NVERT];
	logic signed [15:0] vy_mem[NVERT];
	int vcount = 0;
	logic clip_on = 1'b0;
	logic signed [15:0] clip_lo = 16'sd0;
	logic signed [15:0] clip_hi = 16'sd639;

	function automatic void predict_spans(poly_cmd_t c);
		logic signed [15:0] xs[NCROSS];
		logic signed [15:0] t, l, r;
		longint y1, y2, dy, d1, d2, dx, q;
		int n, nx, k;
		span_t s;
		n = 0;
		k = 0;
		if (!c.cmd) begin
			if (c.fv)
				vcount = 0;
			if (vcount < NVERT) begin
				vx_mem[vcount] = c.x;
				vy_mem[vcount] = c.y;
				vcount++;
			end
			return;
		end
		for (int i = 0; i < vcount; i++) begin
			nx = (i + 1 < vcount) ? i + 1 : 0;
			y1 = vy_mem[i];
			y2 = vy_mem[nx];
			dy = y2 - y1;
			if (dy == 0)
				continue;
			d1 = longint'(c.sy) - y1;
			d2 = longint'(c.sy) - y2;
			if ((d1 < 0) == (d2 < 0))
				continue;
			if (n >= NCROSS)
				break;
			dx = (longint'(vx_mem[nx]) - longint'(vx_mem[i])) * 2;
			if (dx < 0)
				q = ((d2 * dx / dy + 1) >>> 1) + longint'(vx_mem[nx]);
			else
				q = ((d1 * dx / dy + 1) >>> 1) + longint'(vx_mem[i]);
			xs[n] = q[15:0];
			n++;
		end
		for (int i = n; i > 1; i--)
			for (int j = 0; j + 1 < i; j++)
				if (xs[j] > xs[j+1]) begin
					t = xs[j];
					xs[j] = xs[j+1];
					xs[j+1] = t;
				end
		for (int i = 0; i < n / 2 && k < ResultLimit; i++) begin
			l = xs[2*i];
			r = xs[2*i+1];
			if (clip_on) begin
				if (l < clip_lo) begin
					if (r < clip_lo)
						continue;
					l = clip_lo;
				end
				if (r > clip_hi) begin
					if (l > clip_hi)
						continue;
					r = clip_hi;
				end
			end
			s = '{1'b1, l, r, c.sy, 1'b0};
			span_q.push_back(s);
			k++;
		end
		if (k == 0) begin
			s = '{1'b0, 16'sd0, 16'sd0, c.sy, 1'b1};
			span_q.push_back(s);
		end else
			span_q[$].last = 1'b1;
	endfunction

	// driver: hold each item until accepted, then advance
	always @(posedge clk) begin
		if (start && !busy)
			predict_spans(cur);
		if (!(start && busy)) begin
			if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				cur = cmd_q.pop_front();
				cmd <= cur.cmd;
				first_vertex <= cur.fv;
				vertex_x <= cur.x;
				vertex_y <= cur.y;
				scan_y <= cur.sy;
				start <= 1'b1;
				if (!no_idle && $urandom_range(0, 4) == 0)
					gap = $urandom_range(1, 13);
			end else
				start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		span_t e;
		if (span_strobe) begin
			if (span_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected span: valid %0b l %0d r %0d row %0d last %0b",
						span_valid, span_left, span_right, span_row, last);
			end else begin
				e = span_q.pop_front();
				if (span_valid !== e.valid || span_left !== e.left || span_right !== e.right ||
					span_row !== e.row || last !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("span diff: exp %0b %0d %0d %0d %0b got %0b %0d %0d %0d %0b",
							e.valid, e.left, e.right, e.row, e.last, span_valid, span_left,
							span_right, span_row, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("scanline_polygon_span_gen_top: mismatch");
			$finish;
		end
	end

	task automatic push_item(logic c, logic fv, int x, int y, int sy);
		poly_cmd_t p;
		p.cmd = c;
		p.fv = fv;
		p.x = x[15:0];
		p.y = y[15:0];
		p.sy = sy[15:0];
		cmd_q.push_back(p);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegClipEnable)
			clip_on = val[0];
		else if (idx == RegClipXMin)
			clip_lo = val;
		else
			clip_hi = val;
	endtask

	// drain: all items taken, all spans seen, block idle for a while
	task automatic drain();
		int quiet;
		quiet = 0;
		while (quiet < 60) begin
			@(posedge clk);
			if (cmd_q.size() == 0 && !start && gap == 0 && span_q.size() == 0 && !busy)
				quiet++;
			else
				quiet = 0;
		end
	endtask

	function automatic int rnd_coord(int span);
		if ($urandom_range(0, 9) == 0)
			return $signed(16'($urandom()));
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// random polygon followed by scans across its y range, with some noise
	task automatic random_polygon();
		int nv, span, ylo, yhi, y;
		span = ($urandom_range(0, 3) == 0) ? 30000 : 700;
		nv = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 9);
		ylo = 32767;
		yhi = -32768;
		for (int i = 0; i < nv; i++) begin
			y = rnd_coord(span);
			if (y < ylo) ylo = y;
			if (y > yhi) yhi = y;
			push_item(1'b0, i == 0, rnd_coord(span), y, $urandom());
		end
		if ($urandom_range(0, 5) == 0)
			push_item(1'b0, 1'b0, rnd_coord(span), rnd_coord(span), $urandom());
		for (int i = $urandom_range(2, 5); i > 0; i--) begin
			if ($urandom_range(0, 7) == 0)
				y = $signed(16'($urandom()));
			else
				y = int'($urandom_range(0, yhi - ylo + 4)) + ylo - 2;
			if (y > 32767) y = 32767;
			if (y < -32768) y = -32768;
			push_item(1'b1, 1'($urandom()), $urandom(), $urandom(), y);
		end
	endtask

	initial begin
		int scans;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, lone vertex, square, extreme triangle, zigzag
		push_item(1'b1, 1'b1, 100, 100, 0);
		push_item(1'b0, 1'b1, 5, 5, 0);
		push_item(1'b1, 1'b0, 0, 0, 5);
		push_item(1'b0, 1'b1, 10, 10, 0);
		push_item(1'b0, 1'b0, 50, 10, 0);
		push_item(1'b0, 1'b0, 50, 50, 0);
		push_item(1'b0, 1'b0, 10, 50, 0);
		push_item(1'b1, 1'b0, 0, 0, 10);
		push_item(1'b1, 1'b0, 0, 0, 30);
		push_item(1'b1, 1'b0, 0, 0, 50);
		push_item(1'b0, 1'b1, -32768, -32768, 0);
		push_item(1'b0, 1'b0, 32767, 0, 0);
		push_item(1'b0, 1'b0, -32768, 32767, 0);
		push_item(1'b1, 1'b1, -1, -1, -32768);
		push_item(1'b1, 1'b0, 0, 0, -1);
		push_item(1'b1, 1'b0, 0, 0, 32767);
		drain();
		// zigzag of full store gives the full set of spans
		for (int i = 0; i < NVERT; i++)
			push_item(1'b0, i == 0, i * 10, (i % 2) ? 20 : -20, 0);
		push_item(1'b1, 1'b0, 0, 0, 0);
		drain();

		write_reg(RegClipEnable, 16'd1);
		push_item(1'b1, 1'b0, 0, 0, 0);
		push_item(1'b1, 1'b0, 0, 0, 19);
		drain();
		write_reg(RegClipXMin, 16'h8000);
		write_reg(RegClipXMax, 16'h7fff);
		push_item(1'b1, 1'b0, 0, 0, 5);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			unique case (ph)
				0: begin write_reg(RegClipEnable, 16'd0); end
				1: begin
					write_reg(RegClipEnable, 16'd1);
					write_reg(RegClipXMin, 16'd0);
					write_reg(RegClipXMax, 16'd639);
				end
				2: begin
					write_reg(RegClipXMin, 16'd100);
					write_reg(RegClipXMax, 16'hff9c);
				end
				default: begin
					write_reg(RegClipEnable, 16'($urandom()));
					write_reg(RegClipXMin, 16'($urandom()));
					write_reg(RegClipXMax, 16'($urandom()));
				end
			endcase
			if (ph == 5)
				no_idle = 1;
			scans = 0;
			while (scans < 2) begin
				random_polygon();
				scans++;
			end
			drain();
		end

		if (errors == 0)
			$display("scanline_polygon_span_gen_top: match");
		else
			$display("scanline_polygon_span_gen_top: mismatch");
		$finish;
	end

	// catch spans still owed when the run reaches the cycle limit
	always @(posedge clk)
		if (cycles == CYCLE_LIMIT && span_q.size() != 0)
			errors++;

endmodule
